// File: hw/rtl/bptp_pkg.sv
package bptp_pkg;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_DEPTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GREEN_SIX   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_USE_COLOR   = 2'd2;
    localparam int CFG_DATA_W = 5;

    // Pixel depth codes and the reset depth.
    localparam logic [4:0] DEPTH_MONO   = 5'd1;
    localparam logic [4:0] DEPTH_NIBBLE = 5'd4;
    localparam logic [4:0] DEPTH_BYTE   = 5'd8;
    localparam logic [4:0] DEPTH_PACKED = 5'd16;
    localparam logic [4:0] DEPTH_RESET  = 5'd24;

    // Item kinds carried on tuser.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_LOAD  = 1'b1;

    // Classification thresholds.
    localparam logic [7:0] WHITE_LEVEL = 8'h80;
    localparam logic [9:0] WHITE_SUM   = 10'd384;
    localparam logic [7:0] COLOR_LEVEL = 8'hF0;
    localparam logic [7:0] PLANE_ONES  = 8'hFF;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    // Splits a pixel word into channels: direct 24-bit, or 555/565 packed.
    function automatic rgb_t decode_rgb(input logic [23:0] v, input logic packed16,
                                        input logic six);
        rgb_t c;
        if (!packed16) begin
            c.r = v[23:16];
            c.g = v[15:8];
            c.b = v[7:0];
        end else if (!six) begin
            c.b = {v[4:0], 3'b000};
            c.g = {v[9:8], v[7:5], 3'b000};
            c.r = {v[14:10], 3'b000};
        end else begin
            c.b = {v[4:0], 3'b000};
            c.g = {v[10:8], v[7:5], 2'b00};
            c.r = {v[15:11], 3'b000};
        end
        return c;
    endfunction

    // Per-channel test with color on, luminance sum test otherwise.
    function automatic logic is_whitish(input rgb_t c, input logic color);
        logic [9:0] sum;
        sum = 10'(c.r) + 10'(c.g) + 10'(c.b);
        if (color)
            return (c.r > WHITE_LEVEL) && (c.g > WHITE_LEVEL) && (c.b > WHITE_LEVEL);
        return sum > WHITE_SUM;
    endfunction

    function automatic logic is_colored(input rgb_t c);
        return (c.r > COLOR_LEVEL) || ((c.g > COLOR_LEVEL) && (c.b > COLOR_LEVEL));
    endfunction

endpackage

// File: hw/rtl/bmp_pixel_to_tricolor_planes.sv
// A pixel that closes a byte or a row shows its byte pair on the master side once the
// accepting edge has loaded the input stage and a later edge the result register.
// Throughput: one item per cycle unless m_tready stalls a full pipeline;
// the registered palette read sets the stage split.
// Reset: rst_n clears all control state at once and restores the configuration
// registers to depth 24, 555 layout, color on. Palette contents are undefined until loaded.
module bmp_pixel_to_tricolor_planes
    import bptp_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration write port.
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // Input items.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [31:0]            s_tdata,   // pixel_value[23:0], entry_index[31:24]
    input  logic                   s_tuser,   // op
    input  logic                   s_tlast,   // row_end
    // Result items.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [15:0]            m_tdata,   // black_plane_byte[7:0], color_plane_byte[15:8]
    output logic                   m_tlast    // last_of_row
);

    localparam int ADDR_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam logic [8:0] ENTRY_LIMIT = 9'(PALETTE_ENTRIES);

    // Configuration registers.
    logic [4:0] pixel_depth_reg;
    logic       green_six_reg;
    logic       use_color_reg;

    // Input stage.
    logic        s1_valid_reg;
    logic        s1_indexed_reg;
    logic        s1_in_range_reg;
    logic        s1_last_reg;
    logic [23:0] s1_value_reg;
    logic [1:0]  pal_rd_reg;

    // Packing state.
    logic [7:0] black_acc_reg, black_acc_next;
    logic [7:0] color_acc_reg, color_acc_next;
    logic [2:0] bit_pos_reg;

    // Result register.
    logic        out_valid_reg;
    logic [15:0] out_data_reg;
    logic        out_last_reg;

    // Palette flags, {whitish, colored} per entry.
    logic [1:0] palette_mem [PALETTE_ENTRIES];

    logic        color_on;
    logic        out_free;
    logic        s_accept;
    logic        pixel_accept;
    logic        load_accept;
    logic        indexed;
    logic [7:0]  pix_index;
    logic        pix_in_range;
    logic        load_in_range;
    rgb_t        load_rgb;
    rgb_t        pix_rgb;
    logic        whitish;
    logic        colored;
    logic [7:0]  bit_mask;
    logic        emit;

    assign color_on = use_color_reg && (pixel_depth_reg != DEPTH_MONO);

    // Handshake: the input stage moves when it is empty or the result register can take its item.
    assign out_free     = !out_valid_reg || m_tready;
    assign s_tready     = !s1_valid_reg || out_free;
    assign s_accept     = s_tvalid && s_tready;
    assign pixel_accept = s_accept && (s_tuser == OP_PIXEL);
    assign load_accept  = s_accept && (s_tuser == OP_LOAD);

    // Palette index decode for the indexed depths.
    always_comb
    begin
        indexed = 1'b1;
        unique case (pixel_depth_reg)
            DEPTH_MONO:   pix_index = {7'd0, s_tdata[0]};
            DEPTH_NIBBLE: pix_index = {4'd0, s_tdata[3:0]};
            DEPTH_BYTE:   pix_index = s_tdata[7:0];
            default:
            begin
                pix_index = s_tdata[7:0];
                indexed   = 1'b0;
            end
        endcase
    end

    assign pix_in_range  = {1'b0, pix_index} < ENTRY_LIMIT;
    assign load_in_range = {1'b0, s_tdata[31:24]} < ENTRY_LIMIT;
    assign load_rgb      = decode_rgb(s_tdata[23:0], 1'b0, 1'b0);

    // Palette memory: in-range loads write at accept, pixels read at accept into pal_rd_reg.
    always_ff @(posedge clk)
    begin
        if (load_accept && load_in_range)
        begin
            palette_mem[s_tdata[24 +: ADDR_W]] <=
                {is_whitish(load_rgb, color_on), is_colored(load_rgb)};
        end
        if (pixel_accept)
        begin
            pal_rd_reg <= palette_mem[pix_index[ADDR_W-1:0]];
        end
    end

    // Input stage payload.
    always_ff @(posedge clk)
    begin
        if (s_tready)
        begin
            s1_indexed_reg  <= indexed;
            s1_in_range_reg <= pix_in_range;
            s1_last_reg     <= s_tlast;
            s1_value_reg    <= s_tdata[23:0];
        end
    end

    // Classification of the staged pixel.
    assign pix_rgb = decode_rgb(s1_value_reg, pixel_depth_reg == DEPTH_PACKED, green_six_reg);

    always_comb
    begin
        if (s1_indexed_reg)
        begin
            whitish = s1_in_range_reg && pal_rd_reg[1];
            colored = s1_in_range_reg && pal_rd_reg[0];
        end
        else
        begin
            whitish = is_whitish(pix_rgb, color_on);
            colored = is_colored(pix_rgb);
        end
    end

    // Plane bit update, MSB first.
    assign bit_mask = 8'h80 >> bit_pos_reg;
    assign emit     = (bit_pos_reg == 3'd7) || s1_last_reg;

    always_comb
    begin
        black_acc_next = black_acc_reg;
        color_acc_next = color_acc_reg;
        if (!whitish)
        begin
            if (colored && color_on)
                color_acc_next = color_acc_reg & ~bit_mask;
            else
                black_acc_next = black_acc_reg & ~bit_mask;
        end
    end

    // Result payload is captured when a byte pair closes.
    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg && emit)
        begin
            out_data_reg <= {color_acc_next, black_acc_next};
            out_last_reg <= s1_last_reg;
        end
    end

    // Control state, accumulators and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_depth_reg <= DEPTH_RESET;
            green_six_reg   <= 1'b0;
            use_color_reg   <= 1'b1;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            black_acc_reg   <= PLANE_ONES;
            color_acc_reg   <= PLANE_ONES;
            bit_pos_reg     <= 3'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_PIXEL_DEPTH: pixel_depth_reg <= cfg_data;
                    CFG_GREEN_SIX:   green_six_reg   <= cfg_data[0];
                    CFG_USE_COLOR:   use_color_reg   <= cfg_data[0];
                    default:         ;
                endcase
            end

            if (s_tready)
                s1_valid_reg <= pixel_accept;

            if (out_free)
                out_valid_reg <= s1_valid_reg && emit;

            if (out_free && s1_valid_reg)
            begin
                if (emit)
                begin
                    black_acc_reg <= PLANE_ONES;
                    color_acc_reg <= PLANE_ONES;
                    bit_pos_reg   <= 3'd0;
                end
                else
                begin
                    black_acc_reg <= black_acc_next;
                    color_acc_reg <= color_acc_next;
                    bit_pos_reg   <= bit_pos_reg + 3'd1;
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // A pixel never clears the same bit in both planes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (black_acc_reg | color_acc_reg) == PLANE_ONES)
        else $error("black and color planes both cleared at one position");

    // With color off, no pixel clears a color-plane bit.
    assert property (@(posedge clk) disable iff (!rst_n)
        !color_on |-> (color_acc_next == color_acc_reg))
        else $error("color plane written while color is disabled");

    // After a byte pair closes, packing restarts at the first bit with both planes all ones.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_free && s1_valid_reg && emit) |=>
            (bit_pos_reg == 3'd0 && black_acc_reg == PLANE_ONES &&
             color_acc_reg == PLANE_ONES))
        else $error("packing state not restarted after a byte pair");

    // A stalled result with a staged pixel behind it holds off new input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready && s1_valid_reg) |-> !s_tready)
        else $error("input accepted while the pipeline is full");

endmodule

// File: tb/sv/bmp_pixel_to_tricolor_planes_tb.sv
module bmp_pixel_to_tricolor_planes_tb
    import bptp_pkg::*;
();

    // Depths that are not one of the named codes and so decode as direct color.
    localparam logic [4:0] DEPTH_ODD_LOW  = 5'd2;
    localparam logic [4:0] DEPTH_ODD_HIGH = 5'd20;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 50;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 10;

    typedef struct packed {
        logic [7:0] black;
        logic [7:0] color;
        logic       last;
    } plane_pair_t;

    typedef struct {
        logic [4:0]  depth;
        logic        six;
        logic        color;
        logic        op;
        logic [23:0] value;
        logic [7:0]  entry;
        logic        row_end;
        logic        typed;
        plane_pair_t want;
    } dir_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [31:0]            s_tdata;   // pixel_value[23:0], entry_index[31:24]
    logic                   s_tuser;   // op
    logic                   s_tlast;   // row_end
    logic                   m_tvalid;
    logic                   m_tready;
    logic [15:0]            m_tdata;   // black_plane_byte[7:0], color_plane_byte[15:8]
    logic                   m_tlast;   // last_of_row

    // Shadow copy of the configuration and of the packing state.
    logic [4:0]  cur_depth;
    logic        cur_six;
    logic        cur_color;
    logic [7:0]  blk_acc;
    logic [7:0]  col_acc;
    logic [2:0]  bit_pos;
    logic        pal_white [256];
    logic        pal_color [256];

    plane_pair_t pending_pairs[$];
    dir_row_t    dir_rows[$];
    int          errors;
    int          send_idle;
    int          recv_idle;
    logic        hold_req;
    int          hold_left;
    int          cycle_count;

    bmp_pixel_to_tricolor_planes i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // White test: every channel above the level with color on, else the channel sum.
    function automatic logic looks_white(input rgb_t c, input logic col_en);
        logic [9:0] total;
        total = {2'b00, c.r} + {2'b00, c.g} + {2'b00, c.b};
        if (col_en)
            return (c.r > WHITE_LEVEL) && (c.g > WHITE_LEVEL) && (c.b > WHITE_LEVEL);
        return total > WHITE_SUM;
    endfunction

    function automatic logic looks_colored(input rgb_t c);
        return (c.r > COLOR_LEVEL) || ((c.g > COLOR_LEVEL) && (c.b > COLOR_LEVEL));
    endfunction

    // Channel values on or just above the thresholds half of the time, else extremes or random.
    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h81;
            4: return 8'hF0;
            5: return 8'hF1;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Predicts the byte pair, if any, that one accepted item produces.
    function automatic void pack_planes(input logic op, input logic [23:0] value,
                                        input logic [7:0] entry, input logic row_end,
                                        output logic made, output plane_pair_t pair);
        rgb_t       c;
        logic       col_en;
        logic       white;
        logic       colored;
        logic [7:0] idx;
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] bit_mask;
        made = 1'b0;
        pair = '0;
        col_en = cur_color && (cur_depth != DEPTH_MONO);
        c = value;
        if (op == OP_LOAD)
        begin
            pal_white[entry] = looks_white(c, col_en);
            pal_color[entry] = looks_colored(c);
            return;
        end
        if (cur_depth == DEPTH_MONO || cur_depth == DEPTH_NIBBLE || cur_depth == DEPTH_BYTE)
        begin
            idx = value[7:0] & ~(8'hFF << cur_depth);
            white = pal_white[idx];
            colored = pal_color[idx];
        end
        else
        begin
            if (cur_depth == DEPTH_PACKED)
            begin
                lo = value[7:0];
                hi = value[15:8];
                c.b = {lo[4:0], 3'b000};
                if (!cur_six)
                begin
                    c.g = {hi[1:0], lo[7:5], 3'b000};
                    c.r = {hi[6:2], 3'b000};
                end
                else
                begin
                    c.g = {hi[2:0], lo[7:5], 2'b00};
                    c.r = {hi[7:3], 3'b000};
                end
            end
            white = looks_white(c, col_en);
            colored = looks_colored(c);
        end
        bit_mask = 8'h80 >> bit_pos;
        if (!white)
        begin
            if (colored && col_en)
                col_acc = col_acc & ~bit_mask;
            else
                blk_acc = blk_acc & ~bit_mask;
        end
        if (bit_pos == 3'd7 || row_end)
        begin
            made = 1'b1;
            pair.black = blk_acc;
            pair.color = col_acc;
            pair.last = row_end;
            blk_acc = PLANE_ONES;
            col_acc = PLANE_ONES;
            bit_pos = 3'd0;
        end
        else
            bit_pos = bit_pos + 3'd1;
    endfunction

    // Offers one item with random gaps, then records what it should produce.
    task automatic send_item(input logic op, input logic [23:0] value, input logic [7:0] entry,
                             input logic row_end, input logic typed,
                             input plane_pair_t typed_pair);
        logic        made;
        plane_pair_t pair;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = {entry, value};
        s_tuser = op;
        s_tlast = row_end;
        do
            @(posedge clk);
        while (!s_tready);
        pack_planes(op, value, entry, row_end, made, pair);
        if (made)
            pending_pairs.push_back(typed ? typed_pair : pair);
    endtask

    // Stops offering items and waits until the block has gone quiet.
    task automatic settle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_pairs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = index;
        cfg_data = data;
        if (index == CFG_PIXEL_DEPTH)
            cur_depth = data[4:0];
        else if (index == CFG_GREEN_SIX)
            cur_six = data[0];
        else if (index == CFG_USE_COLOR)
            cur_color = data[0];
    endtask

    // Settles the block and writes all three registers.
    task automatic apply_settings(input logic [4:0] depth, input logic six, input logic color);
        settle();
        write_reg(CFG_PIXEL_DEPTH, depth);
        write_reg(CFG_GREEN_SIX, CFG_DATA_W'(six));
        write_reg(CFG_USE_COLOR, CFG_DATA_W'(color));
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Random pixels and palette loads under one setting.
    task automatic run_phase(input logic [4:0] depth, input logic six, input logic color,
                             input logic hold);
        logic        op;
        logic [23:0] value;
        logic [7:0]  entry;
        logic        row_end;
        apply_settings(depth, six, color);
        if (hold)
            hold_req = 1'b1;
        repeat (PHASE_ITEMS)
        begin
            op = ($urandom_range(0, 99) < 15) ? OP_LOAD : OP_PIXEL;
            entry = 8'($urandom_range(0, 255));
            row_end = ($urandom_range(0, 11) == 0);
            value = {pick_level(), pick_level(), pick_level()};
            if (op == OP_PIXEL && depth != DEPTH_RESET && depth != DEPTH_ODD_LOW
                && depth != DEPTH_ODD_HIGH)
            begin
                value = 24'($urandom_range(0, 24'hFFFFFF));
                if (depth == DEPTH_PACKED && $urandom_range(0, 3) == 0)
                    value[15:0] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            end
            send_item(op, value, entry, row_end, 1'b0, '0);
        end
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                m_tready = 1'b0;
                hold_left = hold_left - 1;
            end
            else
                m_tready = ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // Compares each byte pair with the oldest expected one.
    initial
    begin
        plane_pair_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (pending_pairs.size() == 0)
                begin
                    $error("unexpected byte pair: black %02h color %02h last %0d",
                           m_tdata[7:0], m_tdata[15:8], m_tlast);
                    errors++;
                end
                else
                begin
                    want = pending_pairs.pop_front();
                    if (m_tdata[7:0] !== want.black)
                    begin
                        $error("black_plane_byte: expected %02h, actual %02h",
                               want.black, m_tdata[7:0]);
                        errors++;
                    end
                    if (m_tdata[15:8] !== want.color)
                    begin
                        $error("color_plane_byte: expected %02h, actual %02h",
                               want.color, m_tdata[15:8]);
                        errors++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last_of_row: expected %0d, actual %0d", want.last, m_tlast);
                        errors++;
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("bmp_pixel_to_tricolor_planes_tb: errors");
        $finish;
    end

    // Main sequence: reset, directed rows, palette fill, random phases.
    initial
    begin
        dir_row_t row;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_PIXEL;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        hold_req = 1'b0;
        errors = 0;
        send_idle = 37;
        recv_idle = 78;
        cur_depth = DEPTH_RESET;
        cur_six = 1'b0;
        cur_color = 1'b1;
        blk_acc = PLANE_ONES;
        col_acc = PLANE_ONES;
        bit_pos = 3'd0;

        // Columns: depth, six, color, op, value, entry, row_end, typed, expected pair.
        // Single-pixel rows right after reset: black, white, red.
        dir_rows.push_back('{DEPTH_RESET, 1'b0, 1'b1, OP_PIXEL, 24'h000000, 8'h00, 1'b1,
                             1'b1, '{8'h7F, 8'hFF, 1'b1}});
        dir_rows.push_back('{DEPTH_RESET, 1'b0, 1'b1, OP_PIXEL, 24'hFFFFFF, 8'hFF, 1'b1,
                             1'b1, '{8'hFF, 8'hFF, 1'b1}});
        dir_rows.push_back('{DEPTH_RESET, 1'b0, 1'b1, OP_PIXEL, 24'hFF0000, 8'h00, 1'b1,
                             1'b1, '{8'hFF, 8'h7F, 1'b1}});
        // A full byte that also ends the row, with values on the thresholds.
        dir_rows.push_back('{DEPTH_RESET, 1'b0, 1'b1, OP_PIXEL, 24'h808080, 8'h00, 1'b0,
                             1'b0, '0});
        dir_rows.push_back('{DEPTH_RESET, 1'b0, 1'b1, OP_PIXEL, 24'h818181, 8'h00, 1'b0,
                             1'b0, '0});
        dir_rows.push_back('{DEPTH_RESET, 1'b0, 1'b1, OP_PIXEL, 24'hF1F1F1, 8'h00, 1'b0,
                             1'b0, '0});
        dir_rows.push_back('{DEPTH_RESET, 1'b0, 1'b1, OP_PIXEL, 24'hF0F0F0, 8'h00, 1'b0,
                             1'b0, '0});
        dir_rows.push_back('{DEPTH_RESET, 1'b0, 1'b1, OP_PIXEL, 24'hF10000, 8'h00, 1'b0,
                             1'b0, '0});
        dir_rows.push_back('{DEPTH_RESET, 1'b0, 1'b1, OP_PIXEL, 24'h00F1F0, 8'h00, 1'b0,
                             1'b0, '0});
        dir_rows.push_back('{DEPTH_RESET, 1'b0, 1'b1, OP_PIXEL, 24'h00F1F1, 8'h00, 1'b0,
                             1'b0, '0});
        dir_rows.push_back('{DEPTH_RESET, 1'b0, 1'b1, OP_PIXEL, 24'hFFFFFF, 8'h00, 1'b1,
                             1'b0, '0});
        // Color off: the channel-sum test, and red lands on the black plane.
        dir_rows.push_back('{DEPTH_RESET, 1'b0, 1'b0, OP_PIXEL, 24'h808080, 8'h00, 1'b0,
                             1'b0, '0});
        dir_rows.push_back('{DEPTH_RESET, 1'b0, 1'b0, OP_PIXEL, 24'h808081, 8'h00, 1'b0,
                             1'b0, '0});
        dir_rows.push_back('{DEPTH_RESET, 1'b0, 1'b0, OP_PIXEL, 24'hFF0000, 8'h00, 1'b1,
                             1'b0, '0});
        // Packed words, 555 then 565; upper bits of the value are ignored.
        dir_rows.push_back('{DEPTH_PACKED, 1'b0, 1'b1, OP_PIXEL, 24'hAB7FFF, 8'h00, 1'b0,
                             1'b0, '0});
        dir_rows.push_back('{DEPTH_PACKED, 1'b0, 1'b1, OP_PIXEL, 24'h007C00, 8'h00, 1'b1,
                             1'b0, '0});
        dir_rows.push_back('{DEPTH_PACKED, 1'b1, 1'b1, OP_PIXEL, 24'h00F800, 8'h00, 1'b1,
                             1'b0, '0});
        // Palette loads, then indexed pixels that read them back.
        dir_rows.push_back('{DEPTH_RESET, 1'b0, 1'b1, OP_LOAD, 24'hFFFFFF, 8'h00, 1'b0,
                             1'b0, '0});
        dir_rows.push_back('{DEPTH_RESET, 1'b0, 1'b1, OP_LOAD, 24'hFF0000, 8'h01, 1'b0,
                             1'b0, '0});
        dir_rows.push_back('{DEPTH_RESET, 1'b0, 1'b1, OP_LOAD, 24'h00FFFF, 8'hFF, 1'b1,
                             1'b0, '0});
        dir_rows.push_back('{DEPTH_BYTE, 1'b0, 1'b1, OP_PIXEL, 24'h000100, 8'h00, 1'b0,
                             1'b0, '0});
        dir_rows.push_back('{DEPTH_BYTE, 1'b0, 1'b1, OP_PIXEL, 24'h000001, 8'h00, 1'b0,
                             1'b0, '0});
        dir_rows.push_back('{DEPTH_BYTE, 1'b0, 1'b1, OP_PIXEL, 24'h0000FF, 8'h00, 1'b1,
                             1'b0, '0});
        // Depth 1 forces color off for both the loads and the pixels.
        dir_rows.push_back('{DEPTH_MONO, 1'b0, 1'b1, OP_LOAD, 24'hFF0000, 8'h00, 1'b0,
                             1'b0, '0});
        dir_rows.push_back('{DEPTH_MONO, 1'b0, 1'b1, OP_LOAD, 24'hFFFFFF, 8'h01, 1'b0,
                             1'b0, '0});
        dir_rows.push_back('{DEPTH_MONO, 1'b0, 1'b1, OP_PIXEL, 24'hFFFFFE, 8'h00, 1'b0,
                             1'b0, '0});
        dir_rows.push_back('{DEPTH_MONO, 1'b0, 1'b1, OP_PIXEL, 24'h000001, 8'h00, 1'b1,
                             1'b0, '0});

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed rows; settings change only while the block is quiet.
        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.depth != cur_depth || row.six != cur_six || row.color != cur_color)
                apply_settings(row.depth, row.six, row.color);
            send_item(row.op, row.value, row.entry, row.row_end, row.typed, row.want);
        end

        // Fill the whole palette so that every index read later is defined.
        apply_settings(DEPTH_RESET, 1'b0, 1'b1);
        for (int e = 0; e < 256; e++)
            send_item(OP_LOAD, {pick_level(), pick_level(), pick_level()}, 8'(e),
                      1'($urandom_range(0, 1)), 1'b0, '0);

        // Sender idles less than the receiver.
        run_phase(DEPTH_RESET, 1'b0, 1'b0, 1'b1);
        run_phase(DEPTH_PACKED, 1'b0, 1'b1, 1'b0);
        run_phase(DEPTH_PACKED, 1'b1, 1'b1, 1'b0);
        run_phase(DEPTH_PACKED, 1'b1, 1'b0, 1'b0);

        // Receiver idles less than the sender.
        send_idle = 78;
        recv_idle = 37;
        run_phase(DEPTH_BYTE, 1'b0, 1'b1, 1'b0);
        run_phase(DEPTH_BYTE, 1'b1, 1'b0, 1'b0);
        run_phase(DEPTH_NIBBLE, 1'b0, 1'b1, 1'b0);
        run_phase(DEPTH_MONO, 1'b0, 1'b1, 1'b0);

        // No random idling on either side.
        send_idle = 0;
        recv_idle = 0;
        run_phase(DEPTH_MONO, 1'b1, 1'b0, 1'b1);
        run_phase(DEPTH_ODD_LOW, 1'b0, 1'b1, 1'b0);
        run_phase(DEPTH_ODD_HIGH, 1'b1, 1'b0, 1'b0);
        run_phase(DEPTH_RESET, 1'b1, 1'b1, 1'b0);

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("bmp_pixel_to_tricolor_planes_tb: clean");
        else
            $display("bmp_pixel_to_tricolor_planes_tb: errors");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/bptp_pkg.sv
hw/rtl/bmp_pixel_to_tricolor_planes.sv
tb/sv/bmp_pixel_to_tricolor_planes_tb.sv
